@@ rtl/assembly_line_to_machine_word_assert.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSEMBLY_LINE_TO_MACHINE_WORD_ASSERT_SVH
`define ASSEMBLY_LINE_TO_MACHINE_WORD_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ALW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define ALW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/alw_pkg.sv @@
package alw_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned PART_W   = 32;
  localparam int unsigned PLEN_W   = 3;
  localparam int unsigned DEST_W   = 3;
  localparam int unsigned COMP_W   = 7;
  localparam int unsigned JUMP_W   = 3;

  localparam logic [PLEN_W-1:0] PLEN_MAX   = 3'd4;
  localparam logic [PLEN_W-1:0] PLEN_MATCH = 3'd3;

  localparam logic [2:0] C_PREFIX = 3'b111;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SYMBOL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MNEM = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_SLASH,
    CLS_AT,
    CLS_LPAREN,
    CLS_EQUAL,
    CLS_SEMI,
    CLS_DIGIT
  } char_class_e;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_A,
    MODE_C,
    MODE_COMP,
    MODE_LABEL
  } line_mode_e;

  // One classified character as it travels through the queue.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    char_class_e       cls;
  } beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic              hit;
    logic [COMP_W-1:0] code;
  } match_t;

  typedef struct packed {
    logic [PART_W-1:0] text;
    logic [PLEN_W-1:0] len;
    logic [COMP_W-1:0] code;
  } mnem_t;

  localparam int unsigned DEST_N = 7;
  localparam int unsigned JUMP_N = 7;
  localparam int unsigned COMP_N = 28;

  localparam mnem_t DEST_TAB [DEST_N] = '{
    '{32'h0000004D, 3'd1, 7'd1},  // M
    '{32'h00000044, 3'd1, 7'd2},  // D
    '{32'h00004D44, 3'd2, 7'd3},  // MD
    '{32'h00000041, 3'd1, 7'd4},  // A
    '{32'h0000414D, 3'd2, 7'd5},  // AM
    '{32'h00004144, 3'd2, 7'd6},  // AD
    '{32'h00414D44, 3'd3, 7'd7}   // AMD
  };

  localparam mnem_t JUMP_TAB [JUMP_N] = '{
    '{32'h004A4754, 3'd3, 7'd1},  // JGT
    '{32'h004A4551, 3'd3, 7'd2},  // JEQ
    '{32'h004A4745, 3'd3, 7'd3},  // JGE
    '{32'h004A4C54, 3'd3, 7'd4},  // JLT
    '{32'h004A4E45, 3'd3, 7'd5},  // JNE
    '{32'h004A4C45, 3'd3, 7'd6},  // JLE
    '{32'h004A4D50, 3'd3, 7'd7}   // JMP
  };

  localparam mnem_t COMP_TAB [COMP_N] = '{
    '{32'h00000030, 3'd1, 7'h2A},  // 0
    '{32'h00000031, 3'd1, 7'h3F},  // 1
    '{32'h00002D31, 3'd2, 7'h3A},  // -1
    '{32'h00000044, 3'd1, 7'h0C},  // D
    '{32'h00000041, 3'd1, 7'h30},  // A
    '{32'h00002144, 3'd2, 7'h0D},  // !D
    '{32'h00002141, 3'd2, 7'h31},  // !A
    '{32'h00002D44, 3'd2, 7'h0F},  // -D
    '{32'h00002D41, 3'd2, 7'h33},  // -A
    '{32'h00442B31, 3'd3, 7'h1F},  // D+1
    '{32'h00412B31, 3'd3, 7'h37},  // A+1
    '{32'h00442D31, 3'd3, 7'h0E},  // D-1
    '{32'h00412D31, 3'd3, 7'h32},  // A-1
    '{32'h00442B41, 3'd3, 7'h02},  // D+A
    '{32'h00442D41, 3'd3, 7'h13},  // D-A
    '{32'h00412D44, 3'd3, 7'h07},  // A-D
    '{32'h00442641, 3'd3, 7'h00},  // D&A
    '{32'h00447C41, 3'd3, 7'h15},  // D|A
    '{32'h0000004D, 3'd1, 7'h70},  // M
    '{32'h0000214D, 3'd2, 7'h71},  // !M
    '{32'h00002D4D, 3'd2, 7'h73},  // -M
    '{32'h004D2B31, 3'd3, 7'h77},  // M+1
    '{32'h004D2D31, 3'd3, 7'h72},  // M-1
    '{32'h00442B4D, 3'd3, 7'h42},  // D+M
    '{32'h00442D4D, 3'd3, 7'h53},  // D-M
    '{32'h004D2D44, 3'd3, 7'h47},  // M-D
    '{32'h0044264D, 3'd3, 7'h40},  // D&M
    '{32'h00447C4D, 3'd3, 7'h55}   // D|M
  };

  // Miss returns code zero.
  function automatic match_t match_dest(input logic [PART_W-1:0] text,
                                        input logic [PLEN_W-1:0] len);
    match_t m;
    m = '0;
    for (int i = 0; i < DEST_N; i++) begin
      if (len <= PLEN_MATCH && len == DEST_TAB[i].len && text == DEST_TAB[i].text) begin
        m.hit  = 1'b1;
        m.code = DEST_TAB[i].code;
      end
    end
    return m;
  endfunction

  function automatic match_t match_jump(input logic [PART_W-1:0] text,
                                        input logic [PLEN_W-1:0] len);
    match_t m;
    m = '0;
    for (int i = 0; i < JUMP_N; i++) begin
      if (len <= PLEN_MATCH && len == JUMP_TAB[i].len && text == JUMP_TAB[i].text) begin
        m.hit  = 1'b1;
        m.code = JUMP_TAB[i].code;
      end
    end
    return m;
  endfunction

  function automatic match_t match_comp(input logic [PART_W-1:0] text,
                                        input logic [PLEN_W-1:0] len);
    match_t m;
    m = '0;
    for (int i = 0; i < COMP_N; i++) begin
      if (len <= PLEN_MATCH && len == COMP_TAB[i].len && text == COMP_TAB[i].text) begin
        m.hit  = 1'b1;
        m.code = COMP_TAB[i].code;
      end
    end
    return m;
  endfunction

endpackage

@@ rtl/alw_front.sv @@
module alw_front (
  input  logic [alw_pkg::CHAR_W-1:0] text_char_i,
  input  logic                       line_end_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  alw_pkg::q_status_t         q_status_i,
  output logic                       push_o,
  output alw_pkg::beat_t             beat_o
);

  alw_pkg::char_class_e cls;

  always_comb begin
    priority if (text_char_i == alw_pkg::CH_SPACE)  cls = alw_pkg::CLS_SPACE;
    else if (text_char_i == alw_pkg::CH_SLASH)      cls = alw_pkg::CLS_SLASH;
    else if (text_char_i == alw_pkg::CH_AT)         cls = alw_pkg::CLS_AT;
    else if (text_char_i == alw_pkg::CH_LPAREN)     cls = alw_pkg::CLS_LPAREN;
    else if (text_char_i == alw_pkg::CH_EQUAL)      cls = alw_pkg::CLS_EQUAL;
    else if (text_char_i == alw_pkg::CH_SEMI)       cls = alw_pkg::CLS_SEMI;
    else if (text_char_i >= alw_pkg::CH_ZERO && text_char_i <= alw_pkg::CH_NINE)
                                                    cls = alw_pkg::CLS_DIGIT;
    else                                            cls = alw_pkg::CLS_OTHER;
  end

  assign in_ready_o  = !q_status_i.full;
  assign push_o      = in_valid_i && !q_status_i.full;
  assign beat_o.ch   = text_char_i;
  assign beat_o.last = line_end_i;
  assign beat_o.cls  = cls;

endmodule

@@ rtl/alw_queue.sv @@
module alw_queue #(
  parameter int unsigned Depth = alw_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  alw_pkg::beat_t     beat_i,
  input  logic               pop_i,
  output alw_pkg::beat_t     beat_o,
  output alw_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  alw_pkg::beat_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= beat_i;
    end
  end

  assign beat_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);

endmodule

@@ rtl/alw_back.sv @@
module alw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  alw_pkg::beat_t               beat_i,
  input  alw_pkg::q_status_t           q_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [alw_pkg::WORD_W-1:0]   machine_word_o,
  output logic [alw_pkg::STATUS_W-1:0] status_o
);

  alw_pkg::line_mode_e mode_q, mode_d, eff_mode;
  logic [alw_pkg::ADDR_W-1:0] accum_q, accum_d;
  logic [alw_pkg::PART_W-1:0] part_q, part_d;
  logic [alw_pkg::PLEN_W-1:0] len_q, len_d;
  logic [alw_pkg::DEST_W-1:0] dest_q, dest_d;
  logic [alw_pkg::COMP_W-1:0] comp_q, comp_d;
  logic semi_q, semi_d;
  logic cmt_q, cmt_d;
  logic bad_q, bad_d;

  logic out_valid_q, out_valid_d;
  logic [alw_pkg::WORD_W-1:0]   word_q, word_d;
  logic [alw_pkg::STATUS_W-1:0] stat_q, stat_d;

  logic res_valid;
  logic [alw_pkg::JUMP_W-1:0] jump_code;
  logic [alw_pkg::COMP_W-1:0] fin_comp;
  logic fin_bad;
  alw_pkg::match_t dest_m, comp_m, fin_m;

  // Only a line end needs room in the output register.
  assign pop_o = !q_status_i.empty && (!beat_i.last || !out_valid_q || out_ready_i);

  assign dest_m = alw_pkg::match_dest(part_q, len_q);
  assign comp_m = alw_pkg::match_comp(part_q, len_q);

  always_comb begin
    mode_d   = mode_q;
    accum_d  = accum_q;
    part_d   = part_q;
    len_d    = len_q;
    dest_d   = dest_q;
    comp_d   = comp_q;
    semi_d   = semi_q;
    cmt_d    = cmt_q;
    bad_d    = bad_q;
    eff_mode = (mode_q == alw_pkg::MODE_START) ? alw_pkg::MODE_C : mode_q;
    if (pop_o && !cmt_q && mode_q != alw_pkg::MODE_LABEL) begin
      if (beat_i.cls == alw_pkg::CLS_SLASH) begin
        cmt_d = 1'b1;
      end else if (beat_i.cls != alw_pkg::CLS_SPACE) begin
        if (mode_q == alw_pkg::MODE_START && beat_i.cls == alw_pkg::CLS_AT) begin
          mode_d = alw_pkg::MODE_A;
        end else if (mode_q == alw_pkg::MODE_START && beat_i.cls == alw_pkg::CLS_LPAREN) begin
          mode_d = alw_pkg::MODE_LABEL;
        end else begin
          mode_d = eff_mode;
          if (eff_mode == alw_pkg::MODE_A) begin
            if (beat_i.cls == alw_pkg::CLS_DIGIT) begin
              // accum * 10 + digit, kept to 15 bits
              accum_d = (accum_q << 3) + (accum_q << 1)
                        + alw_pkg::ADDR_W'(beat_i.ch[3:0]);
            end else begin
              bad_d = 1'b1;
            end
            if (len_q < alw_pkg::PLEN_MAX) begin
              len_d = len_q + 1'b1;
            end
          end else if (!semi_q && beat_i.cls == alw_pkg::CLS_EQUAL
                       && eff_mode == alw_pkg::MODE_C) begin
            dest_d = dest_m.code[alw_pkg::DEST_W-1:0];
            bad_d  = bad_q || !dest_m.hit;
            part_d = '0;
            len_d  = '0;
            mode_d = alw_pkg::MODE_COMP;
          end else if (!semi_q && beat_i.cls == alw_pkg::CLS_SEMI) begin
            comp_d = comp_m.code;
            bad_d  = bad_q || !comp_m.hit;
            part_d = '0;
            len_d  = '0;
            semi_d = 1'b1;
          end else begin
            part_d = {part_q[alw_pkg::PART_W-alw_pkg::CHAR_W-1:0], beat_i.ch};
            if (len_q < alw_pkg::PLEN_MAX) begin
              len_d = len_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // Final part: jump after ';', comp otherwise.
  assign fin_m = semi_d ? alw_pkg::match_jump(part_d, len_d)
                        : alw_pkg::match_comp(part_d, len_d);
  assign fin_comp  = semi_d ? comp_d : fin_m.code;
  assign jump_code = semi_d ? fin_m.code[alw_pkg::JUMP_W-1:0] : '0;
  assign fin_bad   = bad_d || !fin_m.hit;

  always_comb begin
    res_valid = 1'b0;
    word_d    = word_q;
    stat_d    = stat_q;
    if (pop_o && beat_i.last) begin
      unique case (mode_d)
        alw_pkg::MODE_A: begin
          res_valid = 1'b1;
          if (bad_d || len_d == '0) begin
            word_d = '0;
            stat_d = alw_pkg::STATUS_SYMBOL;
          end else begin
            word_d = {1'b0, accum_d};
            stat_d = alw_pkg::STATUS_OK;
          end
        end
        alw_pkg::MODE_C, alw_pkg::MODE_COMP: begin
          res_valid = 1'b1;
          word_d    = {alw_pkg::C_PREFIX, fin_comp, dest_d, jump_code};
          stat_d    = fin_bad ? alw_pkg::STATUS_BAD_MNEM : alw_pkg::STATUS_OK;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= alw_pkg::MODE_START;
      accum_q     <= '0;
      part_q      <= '0;
      len_q       <= '0;
      dest_q      <= '0;
      comp_q      <= '0;
      semi_q      <= 1'b0;
      cmt_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o && beat_i.last) begin
        // line done: per-line state back to its start values
        mode_q  <= alw_pkg::MODE_START;
        accum_q <= '0;
        part_q  <= '0;
        len_q   <= '0;
        dest_q  <= '0;
        comp_q  <= '0;
        semi_q  <= 1'b0;
        cmt_q   <= 1'b0;
        bad_q   <= 1'b0;
      end else begin
        mode_q  <= mode_d;
        accum_q <= accum_d;
        part_q  <= part_d;
        len_q   <= len_d;
        dest_q  <= dest_d;
        comp_q  <= comp_d;
        semi_q  <= semi_d;
        cmt_q   <= cmt_d;
        bad_q   <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    stat_q <= stat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign machine_word_o = word_q;
  assign status_o       = stat_q;

endmodule

@@ rtl/assembly_line_to_machine_word.sv @@
// Assembles one line of Hack assembly text, fed one character per beat, into a
// 16-bit machine word. The beat flagged by line_end_i closes the line; a line
// that holds an A or C instruction yields one result beat, while empty, label
// and comment-only lines yield none. Spaces are skipped and '/' starts a
// comment to line end. '@' plus decimal digits gives the low 15 bits of the
// value (status 1 if the operand is symbolic or missing, word zero); other
// lines are split at the first '=' and ';' and encoded as 111a cccc ccdd djjj,
// an unknown mnemonic leaving its field zero and giving status 2. Symbols are
// not resolved. Throughput is one character per clock: the back end updates
// the line state for one queued character each cycle, unless a line end waits
// for a held result to be taken. A line's result is loaded into the output
// register when its last beat is popped from the queue. The front end only
// stalls when the character queue (QueueDepth entries) is full, which happens
// only while a finished result waits on out_ready_i.
module assembly_line_to_machine_word #(
  parameter int unsigned QueueDepth = alw_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // character stream
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [alw_pkg::CHAR_W-1:0]   text_char_i,
  input  logic                         line_end_i,
  // machine words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [alw_pkg::WORD_W-1:0]   machine_word_o,
  output logic [alw_pkg::STATUS_W-1:0] status_o
);

  `include "assembly_line_to_machine_word_assert.svh"

  alw_pkg::beat_t     push_beat;
  alw_pkg::beat_t     head_beat;
  alw_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  // Front end: classify each character and queue it.
  alw_front u_front (
    .text_char_i (text_char_i),
    .line_end_i  (line_end_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_status_i  (q_status),
    .push_o      (push),
    .beat_o      (push_beat)
  );

  // Short queue decouples the two sides.
  alw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .beat_i   (push_beat),
    .pop_i    (pop),
    .beat_o   (head_beat),
    .status_o (q_status)
  );

  // Back end: line state, table match, word assembly and output register.
  alw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (head_beat),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .machine_word_o (machine_word_o),
    .status_o       (status_o)
  );

  // A beat taken in is held in the queue until the back end consumes it.
  `ALW_ASSERT_NEXT(a_push_fills_queue, in_valid_i && in_ready_o, !q_status.empty,
                   "accepted beat did not reach the queue")
  // Symbolic or missing operand always yields a zero word.
  `ALW_ASSERT_NOW(a_symbol_word_zero, out_valid_o && status_o == alw_pkg::STATUS_SYMBOL,
                  machine_word_o == '0, "symbol status with nonzero word")
  // An unknown mnemonic can only come from a C instruction.
  `ALW_ASSERT_NOW(a_bad_mnem_is_c,
                  out_valid_o && status_o == alw_pkg::STATUS_BAD_MNEM,
                  machine_word_o[alw_pkg::WORD_W-1 -: 3] == alw_pkg::C_PREFIX,
                  "mnemonic error on a word that is not C form")
  // Back end never pops an empty queue.
  `ALW_ASSERT_NOW(a_no_pop_empty, pop, !q_status.empty, "pop from empty queue")

endmodule
